/* src/ssp_pkg.sv */
// shared types, constants and field layouts of the serial port master
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ssp_pkg;

	// data fifo geometry
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int FIFO_HALF  = FIFO_DEPTH / 2;

	// decoded request queue between front and back
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	// control1 bits
	localparam int CR1_RXIE = 0;
	localparam int CR1_TXIE = 1;
	localparam int CR1_ORIE = 2;
	localparam int CR1_LBM  = 3;
	localparam int CR1_SSE  = 4;

	// interrupt status bits
	localparam int IS_RX = 0;
	localparam int IS_TX = 1;
	localparam int IS_OR = 2;
	localparam int IS_RT = 3;

	localparam logic [7:0] PRESCALE_MASK = 8'hfe;

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_TICK  = 2'd2,
		REQ_NOP   = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		REG_CR0      = 3'd0,
		REG_CR1      = 3'd1,
		REG_DATA     = 3'd2,
		REG_STATUS   = 3'd3,
		REG_PRESCALE = 3'd4,
		REG_ICR      = 3'd5,
		REG_TIMEOUT  = 3'd6,
		REG_UNMAPPED = 3'd7
	} reg_index_t;

	// what the back end has to do with a request
	typedef enum logic [1:0] {
		CMD_IDLE  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		reg_index_t  idx;
		logic [31:0] wdata;
		logic [15:0] rxw;
	} cmd_t;

	// result layout, read_data in the lowest bits
	typedef struct packed {
		logic        irq_combined;
		logic        irq_rx_timeout;
		logic        irq_receive;
		logic        irq_transmit;
		logic        irq_overrun;
		logic [4:0]  tx_bits;
		logic [15:0] tx_word;
		logic        tx_valid;
		logic        access_ok;
		logic [31:0] read_data;
	} result_t;

	typedef struct packed {
		logic [CMDQ_CNT_W-1:0] count;
		logic                  full;
		logic                  empty;
	} cmdq_status_t;

endpackage

/* src/ssp_serial_port_controller_unit.sv */
// top level of the synchronous serial port master
// depends on ssp_pkg, ssp_front, ssp_cmd_queue and ssp_exec
//
//   channel  dir  handshake               payload
//   s_axis   in   s_axis_tvalid/tready    tdata: write_data, rx_word
//                                         tuser: req_type, reg_index, full_word
//   m_axis   out  m_axis_tvalid/tready    tdata: read_data .. irq_combined
//
// one request per cycle sustained while the command queue is not full;
// each request gives exactly one result, via front register, queue and result register
// the back end applies every register and fifo update of a request as it accepts it
// asynchronous reset clears all control state; fifo contents are undefined until written
// a four-entry queue lets the front keep accepting while the output stalls
`timescale 1ns / 1ps

module ssp_serial_port_controller_unit
	import ssp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // write_data[31:0], rx_word[47:32]
	input  logic [5:0]  s_axis_tuser,  // req_type[1:0], reg_index[4:2], full_word[5]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata   // read_data[31:0], access_ok[32], tx_valid[33],
	                                    // tx_word[49:34], tx_bits[54:50], irq_overrun[55],
	                                    // irq_transmit[56], irq_receive[57],
	                                    // irq_rx_timeout[58], irq_combined[59], zero[63:60]
);

	logic         front_valid;
	cmd_t         front_cmd;
	logic         q_push_ready;
	logic         q_pop_valid;
	logic         q_pop_ready;
	cmd_t         q_cmd;
	cmdq_status_t q_status;
	result_t      res;

	// request classification
	ssp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_req    (s_axis_tuser[1:0]),
		.in_idx    (s_axis_tuser[4:2]),
		.in_full   (s_axis_tuser[5]),
		.in_wdata  (s_axis_tdata[31:0]),
		.in_rxw    (s_axis_tdata[47:32]),
		.cmd_valid (front_valid),
		.cmd_ready (q_push_ready),
		.cmd       (front_cmd)
	);

	// decoupling queue
	ssp_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (q_push_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_cmd    (q_cmd),
		.status     (q_status)
	);

	// execution and result register
	ssp_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_pop_valid),
		.cmd_ready (q_pop_ready),
		.cmd       (q_cmd),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {4'b0, res};

	// a command the queue cannot take stays put in the front register
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		front_valid && !q_push_ready |=> front_valid && $stable(front_cmd))
		else $error("front command changed while the queue was full");

	// queue fill never passes its depth, and full and empty exclude each other
	a_queue_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.count <= CMDQ_CNT_W'(CMDQ_DEPTH) && !(q_status.full && q_status.empty))
		else $error("command queue fill out of range");

	// a transfer result is never a bus access and always carries a bit count
	a_tx_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.tx_valid |-> !res.access_ok && res.tx_bits != 5'd0)
		else $error("transfer result with bus access flag or zero bit count");

endmodule

/* src/ssp_front.sv */
// front end: accepts bus requests and ticks, classifies them into commands
// depends on ssp_pkg
`timescale 1ns / 1ps

module ssp_front
	import ssp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  in_req,
	input  logic [2:0]  in_idx,
	input  logic        in_full,
	input  logic [31:0] in_wdata,
	input  logic [15:0] in_rxw,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);

	logic      valid_s1;
	cmd_t      cmd_s1;
	cmd_kind_t kind;
	logic      acc_ok;

	// rejected accesses and no-ops collapse into an idle command
	always_comb begin
		acc_ok = in_full && (reg_index_t'(in_idx) != REG_UNMAPPED);
		kind   = CMD_IDLE;
		case (req_type_t'(in_req))
			REQ_READ: begin
				if (acc_ok) kind = CMD_READ;
			end
			REQ_WRITE: begin
				if (acc_ok && reg_index_t'(in_idx) != REG_STATUS) kind = CMD_WRITE;
			end
			REQ_TICK: kind = CMD_TICK;
			default: kind = CMD_IDLE;
		endcase
	end

	assign in_ready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1.kind  <= kind;
			cmd_s1.idx   <= reg_index_t'(in_idx);
			cmd_s1.wdata <= in_wdata;
			cmd_s1.rxw   <= in_rxw;
		end
	end

endmodule

/* src/ssp_cmd_queue.sv */
// short command queue that decouples the front end from the back end
// depends on ssp_pkg
`timescale 1ns / 1ps

module ssp_cmd_queue
	import ssp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  cmd_t         push_cmd,
	output logic         pop_valid,
	input  logic         pop_ready,
	output cmd_t         pop_cmd,
	output cmdq_status_t status
);

	cmd_t                  mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;
	logic                  push;
	logic                  pop;
	logic                  full;
	logic                  empty;

	function automatic logic [CMDQ_PTR_W-1:0] ptr_inc(input logic [CMDQ_PTR_W-1:0] p);
		ptr_inc = (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign empty      = (count_q == '0);
	assign push_ready = !full;
	assign pop_valid  = !empty;
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign push       = push_valid && !full;
	assign pop        = pop_ready && !empty;

	assign status.count = count_q;
	assign status.full  = full;
	assign status.empty = empty;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

/* src/ssp_exec.sv */
// back end: register file, data fifos, clock divider and interrupt lines
// depends on ssp_pkg; holds the result register toward the output
`timescale 1ns / 1ps

module ssp_exec
	import ssp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	output logic    cmd_ready,
	input  cmd_t    cmd,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	// fifo storage and pointers
	logic [15:0]           txf_q [FIFO_DEPTH];
	logic [15:0]           rxf_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] tx_head_q, tx_head_n, tx_tail;
	logic [FIFO_PTR_W-1:0] rx_head_q, rx_head_n, rx_tail;
	logic [FIFO_CNT_W-1:0] tx_cnt_q, tx_cnt_n;
	logic [FIFO_CNT_W-1:0] rx_cnt_q, rx_cnt_n;

	// registers
	logic [15:0] cr0_q, cr0_n;
	logic [4:0]  cr1_q, cr1_n;
	logic [7:0]  prescale_q, prescale_n;
	logic [15:0] timeout_q, timeout_n;
	logic [3:0]  is_q, is_n;
	logic [15:0] div_q, div_n, div_cur;
	logic [15:0] reload_q, reload_n;
	logic [4:0]  irq_q, irq_n;
	logic        out_valid_q;
	result_t     res_q, res_n;

	logic        exec;
	logic        tx_push, tx_pop, rx_push, rx_pop;
	logic [15:0] tx_head_data, rx_head_data, rx_push_data;
	logic        refresh;
	logic        reload_load;
	logic [7:0]  mul_scr, mul_psc;
	logic [8:0]  scr_p1;
	logic [16:0] prod;

	function automatic logic [FIFO_PTR_W-1:0] ptr_add(input logic [FIFO_PTR_W-1:0] p,
			input logic [FIFO_CNT_W-1:0] n);
		logic [FIFO_CNT_W:0] s;
		s = {{(FIFO_CNT_W + 1 - FIFO_PTR_W){1'b0}}, p} + {1'b0, n};
		if (s >= (FIFO_CNT_W + 1)'(FIFO_DEPTH)) s = s - (FIFO_CNT_W + 1)'(FIFO_DEPTH);
		ptr_add = s[FIFO_PTR_W-1:0];
	endfunction

	assign cmd_ready    = !out_valid_q || res_ready;
	assign exec         = cmd_valid && cmd_ready;
	assign res_valid    = out_valid_q;
	assign res          = res_q;
	assign tx_head_data = txf_q[tx_head_q];
	assign rx_head_data = rxf_q[rx_head_q];
	assign tx_tail      = ptr_add(tx_head_q, tx_cnt_q);
	assign rx_tail      = ptr_add(rx_head_q, rx_cnt_q);

	// divider reload (1+scr)*prescale, recomputed when either operand is written
	assign scr_p1   = {1'b0, mul_scr} + 9'd1;
	assign prod     = {8'b0, scr_p1} * {9'b0, mul_psc};
	assign reload_n = (prod == '0) ? 16'd1 : prod[15:0];

	// command execution
	always_comb begin
		cr0_n        = cr0_q;
		cr1_n        = cr1_q;
		prescale_n   = prescale_q;
		timeout_n    = timeout_q;
		is_n         = is_q;
		div_n        = div_q;
		div_cur      = div_q;
		irq_n        = irq_q;
		tx_push      = 1'b0;
		tx_pop       = 1'b0;
		rx_push      = 1'b0;
		rx_pop       = 1'b0;
		rx_push_data = cmd.rxw;
		refresh      = 1'b0;
		reload_load  = 1'b0;
		mul_scr      = cr0_q[15:8];
		mul_psc      = prescale_q;
		res_n        = '0;
		if (exec) begin
			case (cmd.kind)
				CMD_READ: begin
					res_n.access_ok = 1'b1;
					case (cmd.idx)
						REG_CR0: res_n.read_data = {16'b0, cr0_q};
						REG_CR1: res_n.read_data = {27'b0, cr1_q};
						REG_DATA: begin
							if (rx_cnt_q != '0) begin
								res_n.read_data = {16'b0, rx_head_data};
								rx_pop          = 1'b1;
							end
						end
						REG_STATUS: res_n.read_data = {27'b0,
							tx_cnt_q != '0,
							rx_cnt_q == FIFO_CNT_W'(FIFO_DEPTH),
							rx_cnt_q != '0,
							tx_cnt_q != FIFO_CNT_W'(FIFO_DEPTH),
							tx_cnt_q == '0};
						REG_PRESCALE: res_n.read_data = {24'b0, prescale_q};
						REG_ICR: res_n.read_data = {28'b0, is_q};
						REG_TIMEOUT: res_n.read_data = {16'b0, timeout_q};
						default: res_n.read_data = '0;
					endcase
				end
				CMD_WRITE: begin
					res_n.access_ok = 1'b1;
					case (cmd.idx)
						REG_CR0: begin
							cr0_n       = cmd.wdata[15:0];
							mul_scr     = cmd.wdata[15:8];
							reload_load = 1'b1;
						end
						REG_CR1: begin
							cr1_n = cmd.wdata[4:0];
							if (!cmd.wdata[CR1_ORIE]) is_n[IS_OR] = 1'b0;
							refresh = 1'b1;
						end
						REG_DATA: begin
							if (tx_cnt_q != FIFO_CNT_W'(FIFO_DEPTH)) tx_push = 1'b1;
						end
						REG_PRESCALE: begin
							prescale_n  = cmd.wdata[7:0] & PRESCALE_MASK;
							mul_psc     = cmd.wdata[7:0] & PRESCALE_MASK;
							reload_load = 1'b1;
						end
						REG_ICR: begin
							is_n[IS_OR] = 1'b0;
							refresh     = 1'b1;
						end
						REG_TIMEOUT: begin
							timeout_n   = cmd.wdata[15:0];
							is_n[IS_RT] = 1'b0;
						end
						default: res_n.access_ok = 1'b1;
					endcase
				end
				CMD_TICK: begin
					if (cr1_q[CR1_SSE]) begin
						div_cur = (div_q == '0) ? reload_q : div_q;
						div_n   = div_cur - 16'd1;
						if (div_n == '0) begin
							if (tx_cnt_q != '0) begin
								tx_pop         = 1'b1;
								res_n.tx_valid = 1'b1;
								res_n.tx_word  = tx_head_data;
								res_n.tx_bits  = 5'd1 + {1'b0, cr0_q[3:0]};
								rx_push_data   = cr1_q[CR1_LBM] ? tx_head_data : cmd.rxw;
								if (rx_cnt_q == FIFO_CNT_W'(FIFO_DEPTH)) is_n[IS_OR] = 1'b1;
								else rx_push = 1'b1;
								refresh = 1'b1;
							end else if (timeout_q != '0) begin
								is_n[IS_RT] = 1'b1;
								refresh     = 1'b1;
							end
						end
					end
				end
				default: res_n = '0;
			endcase
		end

		// fifo occupancy after this command
		tx_cnt_n  = tx_cnt_q;
		rx_cnt_n  = rx_cnt_q;
		if (tx_push) tx_cnt_n = tx_cnt_q + 1'b1;
		if (tx_pop) tx_cnt_n = tx_cnt_q - 1'b1;
		if (rx_push) rx_cnt_n = rx_cnt_q + 1'b1;
		if (rx_pop) rx_cnt_n = rx_cnt_q - 1'b1;
		tx_head_n = tx_pop ? ptr_add(tx_head_q, FIFO_CNT_W'(1)) : tx_head_q;
		rx_head_n = rx_pop ? ptr_add(rx_head_q, FIFO_CNT_W'(1)) : rx_head_q;

		// level bits and interrupt lines
		if (refresh) begin
			is_n[IS_TX] = (tx_cnt_n < FIFO_CNT_W'(FIFO_HALF));
			is_n[IS_RX] = (rx_cnt_n >= FIFO_CNT_W'(FIFO_HALF));
			irq_n[0]    = is_n[IS_OR] & cr1_n[CR1_ORIE];
			irq_n[1]    = is_n[IS_TX] & cr1_n[CR1_TXIE];
			irq_n[2]    = is_n[IS_RX] & cr1_n[CR1_RXIE];
			irq_n[3]    = is_n[IS_RT];
			irq_n[4]    = (|(is_n[2:0] & cr1_n[2:0])) | is_n[IS_RT];
		end

		res_n.irq_overrun    = irq_n[0];
		res_n.irq_transmit   = irq_n[1];
		res_n.irq_receive    = irq_n[2];
		res_n.irq_rx_timeout = irq_n[3];
		res_n.irq_combined   = irq_n[4];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_head_q   <= '0;
			rx_head_q   <= '0;
			tx_cnt_q    <= '0;
			rx_cnt_q    <= '0;
			cr0_q       <= '0;
			cr1_q       <= '0;
			prescale_q  <= '0;
			timeout_q   <= '0;
			is_q        <= '0;
			div_q       <= '0;
			reload_q    <= 16'd1;
			irq_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			tx_head_q  <= tx_head_n;
			rx_head_q  <= rx_head_n;
			tx_cnt_q   <= tx_cnt_n;
			rx_cnt_q   <= rx_cnt_n;
			cr0_q      <= cr0_n;
			cr1_q      <= cr1_n;
			prescale_q <= prescale_n;
			timeout_q  <= timeout_n;
			is_q       <= is_n;
			div_q      <= div_n;
			irq_q      <= irq_n;
			if (reload_load) reload_q <= reload_n;
			if (exec) out_valid_q <= 1'b1;
			else if (res_ready) out_valid_q <= 1'b0;
		end
	end

	// fifo entries and result payload
	always_ff @(posedge clk) begin
		if (tx_push) txf_q[tx_tail] <= cmd.wdata[15:0];
		if (rx_push) rxf_q[rx_tail] <= rx_push_data;
		if (exec) res_q <= res_n;
	end

endmodule
